// ----- sv/rcsa_pkg.sv -----
// Shared types and reset constants for the RC switch arm sequencer.
`default_nettype none

package rcsa_pkg;

    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] CFG_ZERO_THR = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_DOWN_THR = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_UP_THR = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_MID_THR = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_TIMEOUT = 3'd4;

    localparam logic [14:0] ZERO_THR_RST = 15'd80;
    localparam logic signed [15:0] DOWN_THR_RST = 16'sd700;
    localparam logic signed [15:0] UP_THR_RST = -16'sd700;
    localparam logic [14:0] MID_THR_RST = 15'd200;
    localparam logic [15:0] TIMEOUT_RST = 16'd1000;

    localparam logic [1:0] STEP_WAIT_MID = 2'd0;
    localparam logic [1:0] STEP_WAIT_DOWN = 2'd1;
    localparam logic [1:0] STEP_WAIT_UP = 2'd2;

    typedef struct packed {
        logic [14:0]        zero_thr;
        logic signed [15:0] down_thr;
        logic signed [15:0] up_thr;
        logic [14:0]        mid_thr;
        logic [15:0]        timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic               rc_present;
        logic               rc_online;
        logic signed [15:0] stick_a;
        logic signed [15:0] stick_b;
        logic signed [15:0] stick_c;
        logic signed [15:0] stick_d;
        logic signed [15:0] manual_switch;
        logic signed [15:0] limit_switch;
        logic signed [15:0] safe_switch;
        logic [31:0]        time_ms;
        logic               in_standby;
    } item_t;

    typedef struct packed {
        logic base;
        logic man_down;
        logic safe_ctr;
        logic safe_dn;
        logic safe_up;
    } flags_t;

    typedef struct packed {
        logic       armed;
        logic       req_ready;
        logic       req_manual;
        logic       req_auto;
        logic       req_standby;
        logic [1:0] seq_step;
    } result_t;

endpackage

`default_nettype wire

// ----- sv/rcsa_classify.sv -----
// Threshold comparisons on one radio snapshot.
`default_nettype none

module rcsa_classify (
    input  wire rcsa_pkg::item_t item,
    input  wire rcsa_pkg::cfg_t  cfg,
    output rcsa_pkg::flags_t     flags
);
    import rcsa_pkg::*;

    logic signed [16:0] zero_pos;
    logic signed [16:0] zero_neg;
    logic signed [16:0] mid_pos;
    logic signed [16:0] mid_neg;

    function automatic logic centred(input logic signed [15:0] v,
                                     input logic signed [16:0] hi,
                                     input logic signed [16:0] lo);
        logic signed [16:0] vx;
        vx = {v[15], v};
        return (vx <= hi) && (vx >= lo);
    endfunction

    assign zero_pos = {2'b00, cfg.zero_thr};
    assign zero_neg = -zero_pos;
    assign mid_pos = {2'b00, cfg.mid_thr};
    assign mid_neg = -mid_pos;

    logic signed [16:0] safe_x;
    assign safe_x = {item.safe_switch[15], item.safe_switch};

    assign flags.man_down = item.manual_switch >= cfg.down_thr;
    assign flags.safe_dn = item.safe_switch >= cfg.down_thr;
    assign flags.safe_up = item.safe_switch <= cfg.up_thr;
    assign flags.safe_ctr = (safe_x > mid_neg) && (safe_x < mid_pos);
    assign flags.base = item.rc_online
        && centred(item.stick_a, zero_pos, zero_neg)
        && centred(item.stick_b, zero_pos, zero_neg)
        && centred(item.stick_c, zero_pos, zero_neg)
        && centred(item.stick_d, zero_pos, zero_neg)
        && flags.man_down
        && (item.limit_switch >= cfg.down_thr);

endmodule

`default_nettype wire

// ----- sv/rcsa_seq.sv -----
// Arm sequence state: unlocked flag, step and deadline, plus request flags.
`default_nettype none

module rcsa_seq (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    advance,
    input  wire                    rc_present,
    input  wire                    in_standby,
    input  wire [31:0]             time_ms,
    input  wire [15:0]             timeout_ms,
    input  wire rcsa_pkg::flags_t  flags,
    output rcsa_pkg::result_t      result
);
    import rcsa_pkg::*;

    logic        unlocked_reg, unlocked_next;
    logic [1:0]  step_reg, step_next;
    logic [31:0] deadline_reg, deadline_next;

    logic [31:0] diff;
    logic        timed_out;
    logic        unl_mid;
    logic        force_sb;

    assign diff = time_ms - deadline_reg;
    assign timed_out = (diff != 32'd0) && !diff[31];

    always_comb begin
        unlocked_next = unlocked_reg;
        step_next = step_reg;
        deadline_next = deadline_reg;
        force_sb = 1'b0;
        if (rc_present) begin
            if (!unlocked_reg) begin
                if (!flags.base) begin
                    step_next = STEP_WAIT_MID;
                    deadline_next = '0;
                end else begin
                    case (step_reg)
                        STEP_WAIT_MID: begin
                            if (flags.safe_ctr) step_next = STEP_WAIT_DOWN;
                        end
                        STEP_WAIT_DOWN: begin
                            if (flags.safe_dn) begin
                                step_next = STEP_WAIT_UP;
                                deadline_next = time_ms + {16'd0, timeout_ms};
                            end else if (!flags.safe_ctr) begin
                                step_next = STEP_WAIT_MID;
                            end
                        end
                        STEP_WAIT_UP: begin
                            // timeout wins over the up position
                            if (timed_out) begin
                                step_next = STEP_WAIT_MID;
                                deadline_next = '0;
                            end else if (flags.safe_up) begin
                                unlocked_next = 1'b1;
                            end
                        end
                        default: begin
                            step_next = STEP_WAIT_MID;
                            deadline_next = '0;
                        end
                    endcase
                end
            end
            unl_mid = unlocked_next;
            if (unl_mid && flags.safe_dn) begin
                unlocked_next = 1'b0;
                step_next = STEP_WAIT_MID;
                deadline_next = '0;
                force_sb = 1'b1;
            end
        end else begin
            unl_mid = unlocked_reg;
        end
    end

    always_comb begin
        result.armed = rc_present && unlocked_next;
        result.req_ready = rc_present && unlocked_next && in_standby;
        result.req_manual = rc_present && unlocked_next && !force_sb && flags.man_down;
        result.req_auto = rc_present && unlocked_next && !force_sb && !flags.man_down;
        result.req_standby = force_sb;
        result.seq_step = step_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unlocked_reg <= 1'b0;
            step_reg <= STEP_WAIT_MID;
            deadline_reg <= '0;
        end else if (advance) begin
            unlocked_reg <= unlocked_next;
            step_reg <= step_next;
            deadline_reg <= deadline_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/rc_switch_arm_sequencer.sv -----
// Top level of the RC switch arm sequencer: config, input stage, output stage.
//
// One input word is one radio tick: presence, link flag, four sticks, three
// switch channels, millisecond time and the standby flag. Each word yields
// exactly one result word with the arm flag, the mode requests and the
// current sequence step.
// A word accepted into the input register has its result loaded into the
// result register when the result stage is free, so a receiver stall can
// delay it. Throughput: one word per cycle while the receiver does not stall;
// the state update is a single pass of comparisons, a 32-bit add and a 32-bit
// subtract between the two registers.
// When the receiver stalls, the result register holds and the input
// register fills; s_ready drops only once both are occupied.
// Reset (synchronous, aresetn low) empties both stages, clears the arm
// state and sequence step, and loads the default thresholds.
// The user must write thresholds through cfg_wr_en/cfg_index/cfg_wdata only
// while no word is in flight (not enforced); indexes past timeout are ignored.
`default_nettype none

module rc_switch_arm_sequencer (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            cfg_wr_en,
    input  wire [rcsa_pkg::CfgIdxW-1:0]    cfg_index,
    input  wire [rcsa_pkg::CfgDataW-1:0]   cfg_wdata,
    input  wire                            s_valid,
    output logic                           s_ready,
    input  wire                            s_rc_present,
    input  wire                            s_rc_online,
    input  wire signed [15:0]              s_stick_a,
    input  wire signed [15:0]              s_stick_b,
    input  wire signed [15:0]              s_stick_c,
    input  wire signed [15:0]              s_stick_d,
    input  wire signed [15:0]              s_manual_switch,
    input  wire signed [15:0]              s_limit_switch,
    input  wire signed [15:0]              s_safe_switch,
    input  wire [31:0]                     s_time_ms,
    input  wire                            s_in_standby,
    output logic                           m_valid,
    input  wire                            m_ready,
    output logic                           m_armed,
    output logic                           m_req_ready,
    output logic                           m_req_manual,
    output logic                           m_req_auto,
    output logic                           m_req_standby,
    output logic [1:0]                     m_seq_step
);
    import rcsa_pkg::*;

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t res_reg;
    logic    res_valid_reg;

    flags_t  flags;
    result_t res_next;
    logic    out_free;
    logic    advance;

    assign out_free = !res_valid_reg || m_ready;
    assign advance = item_valid_reg && out_free;
    assign s_ready = !item_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.zero_thr <= ZERO_THR_RST;
            cfg_reg.down_thr <= DOWN_THR_RST;
            cfg_reg.up_thr <= UP_THR_RST;
            cfg_reg.mid_thr <= MID_THR_RST;
            cfg_reg.timeout_ms <= TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ZERO_THR: cfg_reg.zero_thr <= cfg_wdata[14:0];
                CFG_DOWN_THR: cfg_reg.down_thr <= cfg_wdata;
                CFG_UP_THR:   cfg_reg.up_thr <= cfg_wdata;
                CFG_MID_THR:  cfg_reg.mid_thr <= cfg_wdata[14:0];
                CFG_TIMEOUT:  cfg_reg.timeout_ms <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input stage: load a new word whenever it is free or draining
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_ready) begin
            item_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.rc_present <= s_rc_present;
            item_reg.rc_online <= s_rc_online;
            item_reg.stick_a <= s_stick_a;
            item_reg.stick_b <= s_stick_b;
            item_reg.stick_c <= s_stick_c;
            item_reg.stick_d <= s_stick_d;
            item_reg.manual_switch <= s_manual_switch;
            item_reg.limit_switch <= s_limit_switch;
            item_reg.safe_switch <= s_safe_switch;
            item_reg.time_ms <= s_time_ms;
            item_reg.in_standby <= s_in_standby;
        end
    end

    rcsa_classify u_classify (
        .item  (item_reg),
        .cfg   (cfg_reg),
        .flags (flags)
    );

    rcsa_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .rc_present (item_reg.rc_present),
        .in_standby (item_reg.in_standby),
        .time_ms    (item_reg.time_ms),
        .timeout_ms (cfg_reg.timeout_ms),
        .flags      (flags),
        .result     (res_next)
    );

    // result stage: hold while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (out_free) begin
            res_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid = res_valid_reg;
    assign m_armed = res_reg.armed;
    assign m_req_ready = res_reg.req_ready;
    assign m_req_manual = res_reg.req_manual;
    assign m_req_auto = res_reg.req_auto;
    assign m_req_standby = res_reg.req_standby;
    assign m_seq_step = res_reg.seq_step;

`ifndef NO_ASSERTIONS
    a_step_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_seq_step <= STEP_WAIT_UP))
        else $error("sequence step left the legal range");

    a_mode_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_armed) |-> (m_req_manual ^ m_req_auto))
        else $error("armed word without exactly one run request");

    a_force_disarm: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_req_standby) |->
            (!m_armed && !m_req_ready && m_seq_step == STEP_WAIT_MID))
        else $error("forced standby while still armed");

    a_req_needs_arm: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_armed) |-> (!m_req_ready && !m_req_manual && !m_req_auto))
        else $error("mode request without arm");
`endif

endmodule

`default_nettype wire
